@@ src/memory_reservation_admission_assert.svh @@
// Assertion macros for the admission controller; mra_core is the module that uses them.
// Depends on nothing; included by the files that check their own logic.
`ifndef MEMORY_RESERVATION_ADMISSION_ASSERT_SVH
`define MEMORY_RESERVATION_ADMISSION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mra_pkg.sv @@
// Types, codes, reset values and helper functions of the admission controller.
// Depends on nothing; used by every module of the block.
package mra_pkg;

  typedef logic [63:0] u64_t;

  localparam u64_t U64_MAX = {64{1'b1}};
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    REQ_RESERVE  = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_PRESSURE = 2'd2,
    REQ_POLL     = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    FAIL_NONE   = 2'd0,
    FAIL_ENGINE = 2'd1,
    FAIL_HOST   = 2'd2,
    FAIL_ZERO   = 2'd3
  } fail_code_t;

  typedef enum logic [1:0] {
    PRES_NORMAL   = 2'd0,
    PRES_WARNING  = 2'd1,
    PRES_CRITICAL = 2'd2
  } pressure_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT     = 3'd0,
    CFG_HOST_RES  = 3'd1,
    CFG_UNTRACKED = 3'd2,
    CFG_WARNING   = 3'd3,
    CFG_RECOVERY  = 3'd4
  } cfg_idx_t;

  localparam u64_t RST_LIMIT     = 64'd1073741824;
  localparam u64_t RST_HOST_RES  = 64'd536870912;
  localparam u64_t RST_UNTRACKED = 64'd0;
  localparam u64_t RST_WARNING   = 64'd268435456;
  localparam u64_t RST_RECOVERY  = 64'd536870912;

  typedef struct packed {
    u64_t limit;
    u64_t host_res;
    u64_t untracked;
    u64_t warning;
    u64_t recovery;
  } cfg_t;

  typedef struct packed {
    req_kind_t   req_type;
    u64_t        request_bytes;
    u64_t        allocated_bytes;
    u64_t        sparse_bytes;
    u64_t        device_bytes;
    logic        host_valid;
    u64_t        host_available;
    logic [1:0]  pressure_level;
  } item_t;

  // Request after the state-independent sample math.
  typedef struct packed {
    req_kind_t   kind;
    u64_t        bytes;
    logic [1:0]  level;
    u64_t        observed;
    logic        host_valid;
    logic        hv_ok;      // host sample present and above the host reserve
    u64_t        after;      // available minus host reserve
    logic        aw_ok;      // after >= warning margin
    u64_t        aw;         // after minus warning margin
    logic        ar_ok;
    u64_t        ar;         // after minus recovery margin
    logic        warn_zero;
    logic        rec_zero;
  } pre_t;

  // Decision and state snapshot after the request.
  typedef struct packed {
    logic        granted;
    fail_code_t  failure;
    pressure_t   eff;
    logic        constrained;
    u64_t        reserved;
    u64_t        observed;
    logic        lmo_ok;     // observed <= limit
    u64_t        lmo;        // limit minus observed
    logic        hv_ok;
    u64_t        after;
    u64_t        denied;
    logic        host_ok;
  } core_t;

  typedef struct packed {
    logic        granted;
    fail_code_t  failure;
    pressure_t   eff;
    logic        constrained;
    u64_t        reserved_total;
    u64_t        observed_total;
    u64_t        remaining_budget;
    u64_t        host_headroom;
    u64_t        denied_total;
    logic        growth_ok;
    logic        host_growth_ok;
  } out_t;

  // Headroom left after holding x is at least the margin whose offset is given.
  function automatic logic head_ge(logic m_zero, logic off_ok, u64_t off, u64_t x);
    return m_zero || (off_ok && (x <= off));
  endfunction

  // Hysteresis update of the host-constrained flag.
  function automatic logic next_constrained(logic host_valid, logic ge_warn,
                                            logic ge_rec, logic c_in);
    return !host_valid || !ge_warn || (c_in && !ge_rec);
  endfunction

  function automatic pressure_t level_to_pressure(logic [1:0] level);
    pressure_t p;
    case (level)
      2'd0:    p = PRES_NORMAL;
      2'd1:    p = PRES_WARNING;
      default: p = PRES_CRITICAL;
    endcase
    return p;
  endfunction

  function automatic pressure_t eff_of(pressure_t p, logic c);
    pressure_t e;
    case (p)
      PRES_CRITICAL: e = PRES_CRITICAL;
      default:       e = (c || (p == PRES_WARNING)) ? PRES_WARNING : PRES_NORMAL;
    endcase
    return e;
  endfunction

endpackage

@@ src/mra_pre.sv @@
// Sample stage: observed usage and host offsets that do not depend on block state.
// Depends on mra_pkg.
module mra_pre (
  input  logic            clk,
  input  logic            adv,
  input  mra_pkg::item_t  item,
  input  mra_pkg::cfg_t   cfg,
  output mra_pkg::pre_t   pre_r
);

  logic [65:0]       sum3;
  mra_pkg::u64_t     tracked;
  logic [64:0]       aft_ext;
  logic [65:0]       dw_ext;
  logic [65:0]       dr_ext;
  mra_pkg::pre_t     pre_nxt;

  always_comb begin
    sum3 = {2'b00, item.allocated_bytes} + {2'b00, item.sparse_bytes}
         + {2'b00, cfg.untracked};
    tracked = (sum3[65:64] != 2'b00) ? mra_pkg::U64_MAX : sum3[63:0];

    aft_ext = {1'b0, item.host_available} - {1'b0, cfg.host_res};
    // three-operand difference; bit 65 is the sign
    dw_ext  = {2'b00, item.host_available} - {2'b00, cfg.host_res} - {2'b00, cfg.warning};
    dr_ext  = {2'b00, item.host_available} - {2'b00, cfg.host_res} - {2'b00, cfg.recovery};

    pre_nxt.kind       = item.req_type;
    pre_nxt.bytes      = item.request_bytes;
    pre_nxt.level      = item.pressure_level;
    pre_nxt.observed   = (item.device_bytes > tracked) ? item.device_bytes : tracked;
    pre_nxt.host_valid = item.host_valid;
    pre_nxt.hv_ok      = item.host_valid && !aft_ext[64] && (aft_ext[63:0] != '0);
    pre_nxt.after      = aft_ext[63:0];
    pre_nxt.aw_ok      = item.host_valid && !dw_ext[65];
    pre_nxt.aw         = dw_ext[63:0];
    pre_nxt.ar_ok      = item.host_valid && !dr_ext[65];
    pre_nxt.ar         = dr_ext[63:0];
    pre_nxt.warn_zero  = (cfg.warning == '0);
    pre_nxt.rec_zero   = (cfg.recovery == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
    end
  end

endmodule

@@ src/mra_core.sv @@
// Admission stage: reservation state, hysteresis flag, denial counter and decision.
// Depends on mra_pkg and memory_reservation_admission_assert.svh.
`include "memory_reservation_admission_assert.svh"

module mra_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  mra_pkg::pre_t   pre,
  input  mra_pkg::cfg_t   cfg,
  output mra_pkg::core_t  core_r
);

  mra_pkg::u64_t       res_r, res_nxt;
  mra_pkg::u64_t       den_r, den_nxt;
  logic                cons_r, cons_nxt;
  mra_pkg::pressure_t  pres_r, pres_nxt;

  logic [64:0]         lmo_ext;
  logic [64:0]         sum_req;
  logic [64:0]         rel_ext;
  logic                ovf;
  mra_pkg::u64_t       req_w;
  mra_pkg::u64_t       rel_w;
  logic                gw_old, gr_old, gw_req, gr_req, gw_rel, gr_rel;
  logic                gw_fin, gr_fin;
  logic                c_pre, c_mid, c_in;
  logic                engine_fits, host_fits;
  logic                granted_w;
  mra_pkg::fail_code_t fail_w;
  mra_pkg::pressure_t  eff_w;
  mra_pkg::core_t      core_nxt;

  always_comb begin
    lmo_ext = {1'b0, cfg.limit} - {1'b0, pre.observed};
    sum_req = {1'b0, res_r} + {1'b0, pre.bytes};
    ovf     = sum_req[64];
    req_w   = ovf ? mra_pkg::U64_MAX : sum_req[63:0];
    rel_ext = {1'b0, res_r} - {1'b0, pre.bytes};
    rel_w   = rel_ext[64] ? '0 : rel_ext[63:0];

    gw_old = mra_pkg::head_ge(pre.warn_zero, pre.aw_ok, pre.aw, res_r);
    gr_old = mra_pkg::head_ge(pre.rec_zero,  pre.ar_ok, pre.ar, res_r);
    gw_req = mra_pkg::head_ge(pre.warn_zero, pre.aw_ok, pre.aw, req_w);
    gr_req = mra_pkg::head_ge(pre.rec_zero,  pre.ar_ok, pre.ar, req_w);
    gw_rel = mra_pkg::head_ge(pre.warn_zero, pre.aw_ok, pre.aw, rel_w);
    gr_rel = mra_pkg::head_ge(pre.rec_zero,  pre.ar_ok, pre.ar, rel_w);

    c_pre       = mra_pkg::next_constrained(pre.host_valid, gw_old, gr_old, cons_r);
    engine_fits = !ovf && !lmo_ext[64] && (req_w <= lmo_ext[63:0]);
    host_fits   = gw_req;
    // budget fits but host does not: force constrained
    c_mid       = c_pre | (engine_fits & ~host_fits);

    pres_nxt  = pres_r;
    res_nxt   = res_r;
    den_nxt   = den_r;
    c_in      = cons_r;
    gw_fin    = gw_old;
    gr_fin    = gr_old;
    granted_w = 1'b0;
    fail_w    = mra_pkg::FAIL_NONE;

    case (pre.kind)
      mra_pkg::REQ_RESERVE: begin
        if (pre.bytes == '0) begin
          fail_w = mra_pkg::FAIL_ZERO;
        end else begin
          c_in = c_mid;
          if (!engine_fits || !host_fits || c_mid || (pres_r == mra_pkg::PRES_CRITICAL)) begin
            fail_w  = engine_fits ? mra_pkg::FAIL_HOST : mra_pkg::FAIL_ENGINE;
            den_nxt = (den_r == mra_pkg::U64_MAX) ? den_r : den_r + 64'd1;
          end else begin
            res_nxt   = req_w;
            granted_w = 1'b1;
            gw_fin    = gw_req;
            gr_fin    = gr_req;
          end
        end
      end
      mra_pkg::REQ_RELEASE: begin
        res_nxt = rel_w;
        gw_fin  = gw_rel;
        gr_fin  = gr_rel;
      end
      mra_pkg::REQ_PRESSURE: begin
        pres_nxt = mra_pkg::level_to_pressure(pre.level);
      end
      default: begin
      end
    endcase

    cons_nxt = mra_pkg::next_constrained(pre.host_valid, gw_fin, gr_fin, c_in);
    eff_w    = mra_pkg::eff_of(pres_nxt, cons_nxt);

    core_nxt.granted     = granted_w;
    core_nxt.failure     = fail_w;
    core_nxt.eff         = eff_w;
    core_nxt.constrained = cons_nxt;
    core_nxt.reserved    = res_nxt;
    core_nxt.observed    = pre.observed;
    core_nxt.lmo_ok      = !lmo_ext[64];
    core_nxt.lmo         = lmo_ext[63:0];
    core_nxt.hv_ok       = pre.hv_ok;
    core_nxt.after       = pre.after;
    core_nxt.denied      = den_nxt;
    core_nxt.host_ok     = (eff_w != mra_pkg::PRES_CRITICAL) && !cons_nxt && gw_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= '0;
      den_r  <= '0;
      cons_r <= 1'b0;
      pres_r <= mra_pkg::PRES_NORMAL;
    end else if (adv) begin
      res_r  <= res_nxt;
      den_r  <= den_nxt;
      cons_r <= cons_nxt;
      pres_r <= pres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      core_r <= core_nxt;
    end
  end

  `MRA_ASSERT_NEXT(a_grant_books, clk, rst_n, adv && granted_w, res_r == $past(req_w), "granted request not booked")
  `MRA_ASSERT_NEXT(a_deny_counts, clk, rst_n, adv && ((fail_w == mra_pkg::FAIL_ENGINE) || (fail_w == mra_pkg::FAIL_HOST)), (den_r == $past(den_r) + 64'd1) || (den_r == mra_pkg::U64_MAX), "refused request not counted")
  `MRA_ASSERT_NEXT(a_idle_holds, clk, rst_n, !adv, $stable(res_r) && $stable(den_r) && $stable(cons_r) && $stable(pres_r), "state moved without a request")

endmodule

@@ src/mra_fmt.sv @@
// Status stage: remaining budget, host headroom and growth flags from the snapshot.
// Depends on mra_pkg.
module mra_fmt (
  input  logic            clk,
  input  logic            adv,
  input  mra_pkg::core_t  core,
  output mra_pkg::out_t   out_r
);

  logic           used_lt;
  mra_pkg::out_t  out_nxt;

  always_comb begin
    // observed + reserved < limit, saturation included
    used_lt = core.lmo_ok && (core.reserved < core.lmo);

    out_nxt.granted          = core.granted;
    out_nxt.failure          = core.failure;
    out_nxt.eff              = core.eff;
    out_nxt.constrained      = core.constrained;
    out_nxt.reserved_total   = core.reserved;
    out_nxt.observed_total   = core.observed;
    out_nxt.remaining_budget = used_lt ? core.lmo - core.reserved : '0;
    out_nxt.host_headroom    = (core.hv_ok && (core.reserved < core.after))
                             ? core.after - core.reserved : '0;
    out_nxt.denied_total     = core.denied;
    out_nxt.growth_ok        = core.host_ok && used_lt;
    out_nxt.host_growth_ok   = core.host_ok;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

@@ src/memory_reservation_admission.sv @@
// Top level of the memory reservation admission controller: ports, config, pipeline control.
// Depends on mra_pkg, mra_pre, mra_core and mra_fmt.
//
//   channel   direction   handshake            content
//   in_       input       in_valid/in_ready    request kind, bytes, usage and host samples
//   out_      output      out_valid/out_ready  grant, failure code, status snapshot
//   cfg_      input       cfg_valid/cfg_ready  register index and 64-bit write data
//
// One request per cycle sustained while out_ready is high; out_valid rises once a request has passed
// the input register, sample stage, admission stage and status register.
// The admission stage closes its state loop within its own register stage; that sets the rate.
// Reset is synchronous on rst_n low; config returns to its reset values.
// Each stage fills when the one after it stalls, so in_ready drops only
// when all four stages hold requests and out_ready is low. cfg_ready is always high.
module memory_reservation_admission (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [63:0] in_request_bytes,
  input  logic [63:0] in_allocated_bytes,
  input  logic [63:0] in_sparse_bytes,
  input  logic [63:0] in_device_bytes,
  input  logic        in_host_valid,
  input  logic [63:0] in_host_available,
  input  logic [1:0]  in_pressure_level,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_granted,
  output logic [1:0]  out_failure_code,
  output logic [1:0]  out_effective_pressure,
  output logic        out_constrained,
  output logic [63:0] out_reserved_total,
  output logic [63:0] out_observed_total,
  output logic [63:0] out_remaining_budget,
  output logic [63:0] out_host_headroom,
  output logic [63:0] out_denied_total,
  output logic        out_growth_ok,
  output logic        out_host_growth_ok,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  mra_pkg::cfg_t   cfg_r;
  mra_pkg::item_t  item_r;
  mra_pkg::pre_t   pre_r;
  mra_pkg::core_t  core_r;
  mra_pkg::out_t   out_r;

  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // stage k may load when empty or when its contents move on
  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit     <= mra_pkg::RST_LIMIT;
      cfg_r.host_res  <= mra_pkg::RST_HOST_RES;
      cfg_r.untracked <= mra_pkg::RST_UNTRACKED;
      cfg_r.warning   <= mra_pkg::RST_WARNING;
      cfg_r.recovery  <= mra_pkg::RST_RECOVERY;
    end else if (cfg_valid) begin
      case (mra_pkg::cfg_idx_t'(cfg_index))
        mra_pkg::CFG_LIMIT:     cfg_r.limit     <= cfg_data;
        mra_pkg::CFG_HOST_RES:  cfg_r.host_res  <= cfg_data;
        mra_pkg::CFG_UNTRACKED: cfg_r.untracked <= cfg_data;
        mra_pkg::CFG_WARNING:   cfg_r.warning   <= cfg_data;
        mra_pkg::CFG_RECOVERY:  cfg_r.recovery  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      item_r.req_type        <= mra_pkg::req_kind_t'(in_req_type);
      item_r.request_bytes   <= in_request_bytes;
      item_r.allocated_bytes <= in_allocated_bytes;
      item_r.sparse_bytes    <= in_sparse_bytes;
      item_r.device_bytes    <= in_device_bytes;
      item_r.host_valid      <= in_host_valid;
      item_r.host_available  <= in_host_available;
      item_r.pressure_level  <= in_pressure_level;
    end
  end

  mra_pre u_pre (
    .clk   (clk),
    .adv   (va_r && rdy_b),
    .item  (item_r),
    .cfg   (cfg_r),
    .pre_r (pre_r)
  );

  mra_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (vb_r && rdy_c),
    .pre    (pre_r),
    .cfg    (cfg_r),
    .core_r (core_r)
  );

  mra_fmt u_fmt (
    .clk   (clk),
    .adv   (vc_r && rdy_d),
    .core  (core_r),
    .out_r (out_r)
  );

  assign out_valid              = vd_r;
  assign out_granted            = out_r.granted;
  assign out_failure_code       = out_r.failure;
  assign out_effective_pressure = out_r.eff;
  assign out_constrained        = out_r.constrained;
  assign out_reserved_total     = out_r.reserved_total;
  assign out_observed_total     = out_r.observed_total;
  assign out_remaining_budget   = out_r.remaining_budget;
  assign out_host_headroom      = out_r.host_headroom;
  assign out_denied_total       = out_r.denied_total;
  assign out_growth_ok          = out_r.growth_ok;
  assign out_host_growth_ok     = out_r.host_growth_ok;

endmodule
